FILE: hdl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Sequence fragment reassembler package
// Shared constants, status codes and the types passed between the front end,
// the item queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int unsigned SEQ_W   = 31;
  localparam int unsigned OFS_W   = 18;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned CFG_W   = 18;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [15:0]      FULL_FRAG_LEN = 16'd1300;
  localparam logic [OFS_W-1:0] BUFFER_LIMIT  = 18'd131072;
  localparam logic [OFS_W-1:0] CFG_RESET_VAL = 18'd131072;
  localparam logic [OFS_W-1:0] SEQ_BYTES     = 18'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAG_BUF_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG_SIZE  = 1'd1;

  typedef enum logic [2:0] {
    ST_WHOLE       = 3'd0,
    ST_REASSEMBLED = 3'd1,
    ST_STALE       = 3'd2,
    ST_MISSED      = 3'd3,
    ST_ILLEGAL_LEN = 3'd4,
    ST_PARTIAL     = 3'd5,
    ST_TOO_LONG    = 3'd6
  } status_e;

  // One classified packet header.
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             frag;
    logic [OFS_W-1:0] start_lo;
    logic             start_fits;  // start is non-negative and fits the offset width
    logic [LEN_W-1:0] flen;
    logic             len_bad;     // negative or longer than the payload
    logic             len_full;
  } item_t;

  typedef struct packed {
    logic             deliver;
    status_e          status;
    logic [SEQ_W-1:0] dropped;
    logic [OFS_W-1:0] offset;
    logic [LEN_W-1:0] copy_len;
    logic [OFS_W-1:0] msg_len;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/sequence_fragment_reassembler.sv
// ----------------------------------------------------------------------------
// Sequence fragment reassembler
// Receive side of a sequenced datagram channel: drops stale packets, reports
// sequence gaps and tracks in-order fragment reassembly.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    one packet header
//   out      output     out_valid_o / out_ready_i  one status result
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One header per cycle while the queue has room; an accepted header is written
// into the queue, and the back end registers its result in the output register
// when it takes the header from the queue and the output register is free.
// Reset clears the channel state and sets both size registers to 131072.
// The two-entry queue lets the front accept while a result waits on out_ready_i.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_fragment_reassembler (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sfr_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [sfr_pkg::SEQ_W-1:0]     sequence_req_i,
  input  wire logic                          fragmented_i,
  input  wire logic signed [31:0]            fragment_start_i,
  input  wire logic signed [15:0]            fragment_length_i,
  input  wire logic [sfr_pkg::LEN_W-1:0]     payload_bytes_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               deliver_o,
  output logic [2:0]                         status_o,
  output logic [sfr_pkg::SEQ_W-1:0]          dropped_count_o,
  output logic [sfr_pkg::OFS_W-1:0]          write_offset_o,
  output logic [sfr_pkg::LEN_W-1:0]          copy_length_o,
  output logic [sfr_pkg::OFS_W-1:0]          message_length_o
);
  import sfr_pkg::*;

  logic [CFG_W-1:0] frag_buf_size_q;
  logic [CFG_W-1:0] max_msg_size_q;
  logic [OFS_W-1:0] capacity;

  item_t   front_item;
  item_t   queue_item;
  logic    queue_full;
  logic    queue_valid;
  logic    queue_pop;
  logic    push;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frag_buf_size_q <= CFG_RESET_VAL;
      max_msg_size_q  <= CFG_RESET_VAL;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAG_BUF_SIZE: frag_buf_size_q <= cfg_data_i;
        CFG_MAX_MSG_SIZE:  max_msg_size_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign capacity   = (frag_buf_size_q < BUFFER_LIMIT) ? frag_buf_size_q : BUFFER_LIMIT;
  assign in_ready_o = ~queue_full;
  assign push       = in_valid_i & ~queue_full;

  sfr_front u_front (
    .sequence_req_i    (sequence_req_i),
    .fragmented_i      (fragmented_i),
    .fragment_start_i  (fragment_start_i),
    .fragment_length_i (fragment_length_i),
    .payload_bytes_i   (payload_bytes_i),
    .item_o            (front_item)
  );

  sfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_item_o  (queue_item)
  );

  sfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .item_pop_o   (queue_pop),
    .capacity_i   (capacity),
    .max_msg_i    (max_msg_size_q),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign deliver_o        = res.deliver;
  assign status_o         = res.status;
  assign dropped_count_o  = res.dropped;
  assign write_offset_o   = res.offset;
  assign copy_length_o    = res.copy_len;
  assign message_length_o = res.msg_len;

`ifndef SYNTHESIS
  // Only whole or reassembled messages are handed to the receiver.
  a_deliver_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && deliver_o |-> (status_o == ST_WHOLE || status_o == ST_REASSEMBLED))
    else $error("deliver raised with a non-delivering status");

  a_msg_len_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (message_length_o != '0) |-> (status_o == ST_REASSEMBLED))
    else $error("message length set outside a reassembled result");

  a_copy_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (copy_length_o != '0) |->
      (status_o == ST_REASSEMBLED || status_o == ST_PARTIAL || status_o == ST_TOO_LONG))
    else $error("copy length set for a result that stores nothing");

  a_msg_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_REASSEMBLED) |-> (message_length_o >= SEQ_BYTES))
    else $error("reassembled length lacks the sequence bytes");
`endif

endmodule

`default_nettype wire

FILE: hdl/sfr_front.sv
// ----------------------------------------------------------------------------
// Sequence fragment reassembler front end
// Checks the state-independent properties of a packet header.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front (
  input  wire logic [sfr_pkg::SEQ_W-1:0] sequence_req_i,
  input  wire logic                      fragmented_i,
  input  wire logic signed [31:0]        fragment_start_i,
  input  wire logic signed [15:0]        fragment_length_i,
  input  wire logic [sfr_pkg::LEN_W-1:0] payload_bytes_i,
  output sfr_pkg::item_t                 item_o
);
  import sfr_pkg::*;

  logic len_neg;
  logic len_over;

  assign len_neg  = fragment_length_i[15];
  assign len_over = fragment_length_i[14:0] > {4'd0, payload_bytes_i};

  always_comb begin
    item_o.seq        = sequence_req_i;
    item_o.frag       = fragmented_i;
    item_o.start_lo   = fragment_start_i[OFS_W-1:0];
    item_o.start_fits = (fragment_start_i[31:OFS_W] == '0);
    item_o.flen       = fragment_length_i[LEN_W-1:0];
    item_o.len_bad    = len_neg | len_over;
    item_o.len_full   = (fragment_length_i == FULL_FRAG_LEN);
  end

endmodule

`default_nettype wire

FILE: hdl/sfr_queue.sv
// ----------------------------------------------------------------------------
// Sequence fragment reassembler item queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sfr_pkg::item_t push_item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output sfr_pkg::item_t      pop_item_o
);
  import sfr_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = count_q[1];
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sfr_back.sv
// ----------------------------------------------------------------------------
// Sequence fragment reassembler back end
// Applies one header to the channel state and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      item_valid_i,
  input  wire sfr_pkg::item_t            item_i,
  output logic                           item_pop_o,
  input  wire logic [sfr_pkg::OFS_W-1:0] capacity_i,
  input  wire logic [sfr_pkg::OFS_W-1:0] max_msg_i,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output sfr_pkg::result_t               res_o
);
  import sfr_pkg::*;

  logic [SEQ_W-1:0] last_seq_q, last_seq_d;
  logic [SEQ_W-1:0] asm_seq_q, asm_seq_d;
  logic [OFS_W-1:0] asm_bytes_q, asm_bytes_d;
  logic [SEQ_W-1:0] last_gap_q, last_gap_d;
  logic             res_valid_q, res_valid_d;
  result_t          res_q, res_d;

  logic             stale;
  logic [OFS_W-1:0] base;
  logic [OFS_W:0]   sum;

  // The output register frees itself in the same cycle it is taken.
  assign item_pop_o  = item_valid_i & (~res_valid_q | res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign stale = (item_i.seq <= last_seq_q);
  // A fragment of a new sequence restarts assembly from zero bytes.
  assign base  = (item_i.seq != asm_seq_q) ? '0 : asm_bytes_q;
  assign sum   = {1'b0, base} + {{(OFS_W + 1 - LEN_W){1'b0}}, item_i.flen};

  always_comb begin
    last_seq_d  = last_seq_q;
    asm_seq_d   = asm_seq_q;
    asm_bytes_d = asm_bytes_q;
    last_gap_d  = last_gap_q;
    res_d       = '0;
    res_d.status = ST_STALE;

    if (!stale) begin
      last_gap_d = item_i.seq - last_seq_q - {{(SEQ_W - 1){1'b0}}, 1'b1};
      if (!item_i.frag) begin
        last_seq_d    = item_i.seq;
        res_d.deliver = 1'b1;
        res_d.status  = ST_WHOLE;
      end else begin
        asm_seq_d   = item_i.seq;
        asm_bytes_d = base;
        if (!item_i.start_fits || item_i.start_lo != base) begin
          res_d.status = ST_MISSED;
        end else if (item_i.len_bad || sum > {1'b0, capacity_i}) begin
          res_d.status = ST_ILLEGAL_LEN;
        end else begin
          res_d.offset   = base;
          res_d.copy_len = item_i.flen;
          asm_bytes_d    = sum[OFS_W-1:0];
          if (item_i.len_full) begin
            res_d.status = ST_PARTIAL;
          end else if (sum > {1'b0, max_msg_i}) begin
            res_d.status = ST_TOO_LONG;
          end else begin
            res_d.deliver = 1'b1;
            res_d.status  = ST_REASSEMBLED;
            res_d.msg_len = sum[OFS_W-1:0] + SEQ_BYTES;
            asm_bytes_d   = '0;
            last_seq_d    = item_i.seq;
          end
        end
      end
    end
    res_d.dropped = last_gap_d;
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (item_pop_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q  <= '0;
      asm_seq_q   <= '0;
      asm_bytes_q <= '0;
      last_gap_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (item_pop_o) begin
        last_seq_q  <= last_seq_d;
        asm_seq_q   <= asm_seq_d;
        asm_bytes_q <= asm_bytes_d;
        last_gap_q  <= last_gap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

FILE: verif/reassembly_check_pkg.sv
// ----------------------------------------------------------------------------
// Reassembler scoreboard
// Tracks the channel state (last accepted sequence, the sequence being
// assembled, bytes held and the last gap) to predict the result of every
// accepted request, and checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
package reassembly_check_pkg;

  import sfr_pkg::*;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic               frag;
    logic signed [31:0] start;
    logic signed [15:0] flen;
    logic [LEN_W-1:0]   payload;
  } header_t;

  class reassembly_scoreboard;
    logic [CFG_W-1:0] buffer_bytes;
    logic [CFG_W-1:0] max_msg_bytes;
    logic [SEQ_W-1:0] last_seq;
    logic [SEQ_W-1:0] assembling_seq;
    int unsigned      held_bytes;
    logic [SEQ_W-1:0] gap;
    result_t          expected_results[$];
    int unsigned      mismatch_count;
    int unsigned      result_count;

    function new();
      buffer_bytes   = CFG_RESET_VAL;
      max_msg_bytes  = CFG_RESET_VAL;
      last_seq       = '0;
      assembling_seq = '0;
      held_bytes     = 0;
      gap            = '0;
      mismatch_count = 0;
      result_count   = 0;
    endfunction

    function void set_sizes(logic [CFG_W-1:0] cap_bytes, logic [CFG_W-1:0] max_bytes);
      buffer_bytes  = cap_bytes;
      max_msg_bytes = max_bytes;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function result_t predict_status(header_t h);
      result_t     r;
      int unsigned cap;
      int          len;
      r   = '0;
      len = h.flen;
      cap = (buffer_bytes < BUFFER_LIMIT) ? buffer_bytes : BUFFER_LIMIT;
      if (h.seq <= last_seq) begin
        r.status  = ST_STALE;
        r.dropped = gap;
        return r;
      end
      gap       = h.seq - last_seq - 1'b1;
      r.dropped = gap;
      if (!h.frag) begin
        last_seq  = h.seq;
        r.deliver = 1'b1;
        r.status  = ST_WHOLE;
        return r;
      end
      // A fragment of another sequence throws away whatever was assembled.
      if (h.seq != assembling_seq) begin
        assembling_seq = h.seq;
        held_bytes     = 0;
      end
      if (longint'(h.start) != longint'(held_bytes)) begin
        r.status = ST_MISSED;
        return r;
      end
      if (len < 0 || len > int'(h.payload) || held_bytes + len > cap) begin
        r.status = ST_ILLEGAL_LEN;
        return r;
      end
      r.offset   = OFS_W'(held_bytes);
      r.copy_len = LEN_W'(len);
      held_bytes += len;
      if (len == FULL_FRAG_LEN) begin
        r.status = ST_PARTIAL;
        return r;
      end
      // An oversized message keeps its bytes but is never delivered.
      if (held_bytes > max_msg_bytes) begin
        r.status = ST_TOO_LONG;
        return r;
      end
      r.msg_len  = OFS_W'(held_bytes + SEQ_BYTES);
      held_bytes = 0;
      last_seq   = h.seq;
      r.deliver  = 1'b1;
      r.status   = ST_REASSEMBLED;
      return r;
    endfunction

    function void note_request(header_t h);
      expected_results.push_back(predict_status(h));
    endfunction

    task report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
      mismatch_count++;
      $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
               result_count, what, got_v, want_v);
    endtask

    task check_result(result_t got);
      result_t want;
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding, status", got.status, 0);
        return;
      end
      want = expected_results.pop_front();
      if (got.deliver !== want.deliver) report_mismatch("deliver", got.deliver, want.deliver);
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.dropped !== want.dropped) report_mismatch("dropped_count", got.dropped, want.dropped);
      if (got.offset !== want.offset) report_mismatch("write_offset", got.offset, want.offset);
      if (got.copy_len !== want.copy_len) begin
        report_mismatch("copy_length", got.copy_len, want.copy_len);
      end
      if (got.msg_len !== want.msg_len) begin
        report_mismatch("message_length", got.msg_len, want.msg_len);
      end
    endtask
  endclass

endpackage

FILE: verif/tb_sequence_fragment_reassembler.sv
// ----------------------------------------------------------------------------
// Sequence fragment reassembler testbench
// Drives packet header requests through the input channel, first a directed
// set of corner cases, then random traffic made mostly of in-order fragment
// runs under several buffer and message size settings. Every result is
// checked against the scoreboard prediction, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_sequence_fragment_reassembler;

  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;
  import reassembly_check_pkg::*;

  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned RX_HOLD_CYCLES = 60;
  localparam int unsigned IDLE_PCT       = 26;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [SEQ_W-1:0]         sequence_req_i;
  logic                     fragmented_i;
  logic signed [31:0]       fragment_start_i;
  logic signed [15:0]       fragment_length_i;
  logic [LEN_W-1:0]         payload_bytes_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     deliver_o;
  logic [2:0]               status_o;
  logic [SEQ_W-1:0]         dropped_count_o;
  logic [OFS_W-1:0]         write_offset_o;
  logic [LEN_W-1:0]         copy_length_o;
  logic [OFS_W-1:0]         message_length_o;

  reassembly_scoreboard sb;
  bit                   calm;
  bit                   rx_hold_req;
  int unsigned          sent_total;

  // Traffic generator state: the next fresh sequence and the open message.
  logic [SEQ_W-1:0]     next_seq;
  logic [SEQ_W-1:0]     msg_seq;
  int unsigned          msg_off;
  bit                   in_msg;

  sequence_fragment_reassembler u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sequence_req_i    (sequence_req_i),
    .fragmented_i      (fragmented_i),
    .fragment_start_i  (fragment_start_i),
    .fragment_length_i (fragment_length_i),
    .payload_bytes_i   (payload_bytes_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .deliver_o         (deliver_o),
    .status_o          (status_o),
    .dropped_count_o   (dropped_count_o),
    .write_offset_o    (write_offset_o),
    .copy_length_o     (copy_length_o),
    .message_length_o  (message_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    header_t h;
    result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        h.seq     = sequence_req_i;
        h.frag    = fragmented_i;
        h.start   = fragment_start_i;
        h.flen    = fragment_length_i;
        h.payload = payload_bytes_i;
        sb.note_request(h);
      end
      if (out_valid_o && out_ready_i) begin
        got.deliver  = deliver_o;
        got.status   = status_e'(status_o);
        got.dropped  = dropped_count_o;
        got.offset   = write_offset_o;
        got.copy_len = copy_length_o;
        got.msg_len  = message_length_o;
        sb.check_result(got);
      end
    end
  end

  // Result side: random back-pressure, a quiet stretch and one long hold-off.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("** sequence_fragment_reassembler: FAILED **");
    $finish;
  end

  task automatic send_request(logic [SEQ_W-1:0] seq, logic frag, logic signed [31:0] start,
                              logic signed [15:0] flen, logic [LEN_W-1:0] payload);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    sequence_req_i    <= seq;
    fragmented_i      <= frag;
    fragment_start_i  <= start;
    fragment_length_i <= flen;
    payload_bytes_i   <= payload;
    do @(posedge clk_i); while (!in_ready_o);
    sent_total++;
  endtask

  // The first edge lets the monitor record a request accepted on this step.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure_sizes(logic [CFG_W-1:0] cap_bytes, logic [CFG_W-1:0] max_bytes);
    wait_for_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FRAG_BUF_SIZE;
    cfg_data_i <= cap_bytes;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_MSG_SIZE;
    cfg_data_i <= max_bytes;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_sizes(cap_bytes, max_bytes);
  endtask

  function automatic logic [SEQ_W-1:0] next_sequence(logic [SEQ_W-1:0] s);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 85) return s + 1'b1;
    if (pick < 98) return s + SEQ_W'($urandom_range(1000, 2));
    return s + SEQ_W'($urandom_range(1 << 20, 1000));
  endfunction

  task automatic run_traffic(int unsigned count);
    logic [SEQ_W-1:0]   seq;
    logic               frag;
    logic signed [31:0] start;
    logic signed [15:0] flen;
    logic [LEN_W-1:0]   payload;
    int unsigned        pick;
    int unsigned        len;
    bit                 good;
    for (int unsigned n = 0; n < count; n++) begin
      calm = (sent_total >= 150 && sent_total < 350);
      if (sent_total == 500) rx_hold_req = 1'b1;
      if (sent_total == 800) wait_for_results();
      // Whole packets carry random bits in the fields they do not use.
      seq     = next_seq;
      frag    = 1'b0;
      start   = $urandom;
      flen    = 16'($urandom);
      payload = LEN_W'($urandom_range(2047));
      good    = 1'b0;
      pick    = $urandom_range(99);
      if (in_msg && pick < 70) begin
        good = 1'b1;
      end else if (in_msg && pick < 78) begin
        seq   = msg_seq;
        frag  = 1'b1;
        start = $urandom_range(1) ? msg_off + $urandom_range(2600, 1) : $urandom;
        flen  = FULL_FRAG_LEN;
      end else if (in_msg && pick < 86) begin
        seq   = msg_seq;
        frag  = 1'b1;
        start = msg_off;
        if ($urandom_range(1)) begin
          flen = 16'(-$urandom_range(32768, 1));
        end else begin
          payload = LEN_W'($urandom_range(2046));
          flen    = 16'(payload + $urandom_range(30001, 1));
        end
      end else if (pick >= 92) begin
        seq  = SEQ_W'($urandom_range(next_seq));
        frag = 1'($urandom_range(1));
      end else if (!in_msg && pick < 40) begin
        next_seq = next_sequence(next_seq);
        seq      = next_seq;
      end else begin
        // Open a new message; one left unfinished is simply abandoned.
        next_seq = next_sequence(next_seq);
        msg_seq  = next_seq;
        msg_off  = 0;
        in_msg   = 1'b1;
        good     = 1'b1;
      end
      if (good) begin
        len     = ($urandom_range(99) < 65) ? FULL_FRAG_LEN : $urandom_range(2047);
        seq     = msg_seq;
        frag    = 1'b1;
        start   = msg_off;
        flen    = 16'(len);
        payload = LEN_W'($urandom_range(2047, len));
        if (len == FULL_FRAG_LEN) msg_off += len;
        else in_msg = 1'b0;
      end
      send_request(seq, frag, start, flen, payload);
    end
  endtask

  task automatic run_directed();
    // Stale at reset, then a whole packet after a gap and its repeat.
    send_request(31'd0, 1'b0, 32'sd0, 16'sd0, 11'd0);
    send_request(31'd3, 1'b0, -32'sd1, -16'sd1, 11'd2047);
    send_request(31'd3, 1'b0, 32'sd0, 16'sd0, 11'd0);
    // In-order fragments with the error cases interleaved.
    send_request(31'd4, 1'b1, 32'sd0, 16'sd1300, 11'd1300);
    send_request(31'd4, 1'b1, 32'sd0, 16'sd1300, 11'd1300);
    send_request(31'd4, 1'b1, 32'sd1300, -16'sd1, 11'd100);
    send_request(31'd4, 1'b1, 32'sd1300, 16'sd101, 11'd100);
    send_request(31'd4, 1'b1, 32'sd1300, 16'sd1300, 11'd2047);
    send_request(31'd4, 1'b1, 32'sd2600, 16'sd0, 11'd0);
    // Start offsets that can never match, and extreme lengths.
    send_request(31'd6, 1'b1, -32'sd1, 16'sd10, 11'd10);
    send_request(31'd6, 1'b1, 32'sh8000_0000, 16'sd10, 11'd10);
    send_request(31'd6, 1'b1, 32'sh7FFF_FFFF, 16'sd10, 11'd10);
    send_request(31'd6, 1'b1, 32'sd0, -16'sd32768, 11'd2047);
    send_request(31'd6, 1'b1, 32'sd0, 16'sd32767, 11'd2047);
    send_request(31'd6, 1'b1, 32'sd0, 16'sd2047, 11'd2047);
    // A whole packet abandons an open message.
    send_request(31'd7, 1'b1, 32'sd0, 16'sd1300, 11'd1300);
    send_request(31'd9, 1'b0, 32'sd0, 16'sd0, 11'd5);
    send_request(31'd10, 1'b1, 32'sd0, 16'sd1299, 11'd1299);
    send_request(31'd11, 1'b1, 32'sd0, 16'sd1301, 11'd1301);
    // Buffer overrun and oversized messages.
    configure_sizes(18'd2600, 18'd2000);
    send_request(31'd12, 1'b1, 32'sd0, 16'sd1300, 11'd1300);
    send_request(31'd12, 1'b1, 32'sd1300, 16'sd1300, 11'd1300);
    send_request(31'd12, 1'b1, 32'sd2600, 16'sd1, 11'd1);
    send_request(31'd12, 1'b1, 32'sd2600, 16'sd0, 11'd0);
    send_request(31'd13, 1'b1, 32'sd0, 16'sd1300, 11'd1300);
    send_request(31'd13, 1'b1, 32'sd1300, 16'sd800, 11'd800);
    // No buffer at all: only an empty fragment fits.
    configure_sizes(18'd0, 18'd0);
    send_request(31'd14, 1'b1, 32'sd0, 16'sd1, 11'd1);
    send_request(31'd14, 1'b1, 32'sd0, 16'sd0, 11'd0);
  endtask

  initial begin
    sb = new();
    rst_ni            = 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_FRAG_BUF_SIZE;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    sequence_req_i    <= '0;
    fragmented_i      <= 1'b0;
    fragment_start_i  <= '0;
    fragment_length_i <= '0;
    payload_bytes_i   <= '0;
    calm        = 1'b0;
    rx_hold_req = 1'b0;
    sent_total  = 0;
    next_seq    = 31'd20;
    msg_seq     = '0;
    msg_off     = 0;
    in_msg      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    configure_sizes(18'd131072, 18'd131072);
    run_traffic(350);
    configure_sizes(18'd4000, 18'd262143);
    run_traffic(250);
    configure_sizes(18'd262143, 18'd3000);
    run_traffic(250);
    configure_sizes(CFG_W'($urandom_range(20000, 1300)), CFG_W'($urandom_range(20000)));
    run_traffic(250);
    configure_sizes(18'd0, 18'd0);
    run_traffic(60);

    // Accept the top sequence; everything after it is stale.
    send_request(31'h7FFF_FFFF, 1'b1, 32'sd0, 16'sd0, 11'd0);
    repeat (20) begin
      send_request(SEQ_W'($urandom), 1'($urandom_range(1)), $urandom, 16'($urandom),
                   LEN_W'($urandom_range(2047)));
    end

    wait_for_results();
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("** sequence_fragment_reassembler: PASSED **");
    end else begin
      $display("** sequence_fragment_reassembler: FAILED **");
    end
    $finish;
  end

endmodule
